[rtl/core/ssrm_pkg.sv]
// Shared types, codes and constants of the safety stop reaction monitor.
`timescale 1ns / 1ps

package ssrm_pkg;

  // Request kinds carried in the input tuser.
  localparam logic [1:0] KIND_LEVEL = 2'd0;
  localparam logic [1:0] KIND_RAW   = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  // Safety level codes.
  localparam logic signed [15:0] LEVEL_EMERG  = 16'sd0;
  localparam logic signed [15:0] LEVEL_HAZARD = 16'sd1;
  localparam logic signed [15:0] LEVEL_FREE   = 16'sd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_STOP_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_OVERRIDE_MARGIN = 2'd1;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int SPEED_CFG_W = 15;

  localparam logic [SPEED_CFG_W-1:0] STOP_THRESHOLD_RST  = 15'd30;
  localparam logic [SPEED_CFG_W-1:0] OVERRIDE_MARGIN_RST = 15'd50;

  // Counter slots.
  localparam int CNT_EMERG    = 0;
  localparam int CNT_HAZARD   = 1;
  localparam int CNT_FREE     = 2;
  localparam int CNT_CHANGE   = 3;
  localparam int CNT_OVERRIDE = 4;
  localparam int CNT_REACT    = 5;
  localparam int NUM_CNT      = 6;

  // Stream layout.
  localparam int IN_TIME_W   = 48;
  localparam int IN_TIME_LSB = 0;
  localparam int IN_LEVEL_LSB = 48;
  localparam int IN_SPEED_LSB = 64;
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 312;

  // Divider geometry: 32-bit dividend, one quotient bit per cycle.
  localparam int QUO_W  = 32;
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd31;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Magnitude of a 16-bit signed speed, exact for the most negative value.
  function automatic logic [16:0] mag16(input logic [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? (~ext + 17'd1) : ext;
  endfunction

endpackage

[rtl/core/ssrm_divider.sv]
// Bit-serial restoring divider used for the running mean update.
`timescale 1ns / 1ps

module ssrm_divider #(
  parameter int COUNT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ssrm_pkg::QUO_W-1:0] dividend,
  input  logic [COUNT_BITS-1:0]     divisor,
  output logic [ssrm_pkg::QUO_W-1:0] quotient,
  output ssrm_pkg::div_stat_t       stat
);

  logic [COUNT_BITS-1:0]           rem;
  logic [COUNT_BITS-1:0]           dsr;
  logic [ssrm_pkg::QUO_W-1:0]      quo;
  logic [ssrm_pkg::STEP_W-1:0]     step;
  logic                            busy;
  logic                            done;

  logic [COUNT_BITS:0]             trial;
  logic                            fits;
  logic [COUNT_BITS:0]             rem_next;

  // One restoring step: shift in the next dividend bit and try the divisor.
  always_comb begin
    trial    = {rem, quo[ssrm_pkg::QUO_W-1]};
    fits     = trial >= {1'b0, dsr};
    rem_next = fits ? (trial - {1'b0, dsr}) : trial;
  end

  // Iteration control; the quotient collects in the dividend register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == ssrm_pkg::LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        dsr  <= divisor;
        quo  <= dividend;
      end else if (busy) begin
        rem  <= rem_next[COUNT_BITS-1:0];
        quo  <= {quo[ssrm_pkg::QUO_W-2:0], fits};
        step <= step + 1'b1;
        if (step == ssrm_pkg::LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[rtl/core/safety_stop_reaction_monitor_unit.sv]
// Top level of the safety stop reaction monitor.
//
//   Channel  Dir  Handshake                  Payload
//   s_axis   in   s_axis_tvalid/tready       tdata: time, level, speed; tuser: kind
//   m_axis   out  m_axis_tvalid/tready       tdata: level, counters, reaction stats
//   cfg      in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A result is offered once the item has passed the execute state and, when the item
// records a reaction time, also the mean update: a bit-serial divider that resolves
// one quotient bit per cycle. The input reopens in the cycle after the result transfer,
// and an output stall holds the item until its result is taken.
// The input is ready only while no item is in work; a result waits in the
// output register until taken. Synchronous reset restores all statistics.
`timescale 1ns / 1ps

module safety_stop_reaction_monitor_unit #(
  parameter int COUNT_BITS = 32,
  parameter int TIME_BITS  = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  // tdata: time_us[47:0], signal_level[63:48], speed_mm_s[79:64]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ssrm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [ssrm_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  // tdata: level_now[15:0], emergency_total[47:16], hazard_total[79:48],
  // free_total[111:80], change_total[143:112], override_total[175:144],
  // reaction_total[207:176], reaction_min_us[239:208],
  // reaction_max_us[271:240], reaction_mean_us[303:272], awaiting_stop[304]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ssrm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssrm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ssrm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_OUT} state_t;

  state_t state;

  // Configuration.
  logic [ssrm_pkg::SPEED_CFG_W-1:0] stop_threshold;
  logic [ssrm_pkg::SPEED_CFG_W-1:0] override_margin;

  // Latched input item.
  logic [1:0]                item_kind;
  logic [TIME_BITS-1:0]      item_time;
  logic signed [15:0]        item_level;
  logic [15:0]               item_speed;

  // Monitor state.
  logic signed [15:0]        level_reg;
  logic                      level_seen;
  logic [15:0]               raw_speed_reg;
  logic                      raw_seen;
  logic                      stop_pending;
  logic [TIME_BITS-1:0]      emergency_time;
  logic [COUNT_BITS-1:0]     cnt [ssrm_pkg::NUM_CNT];
  logic [31:0]               reaction_min;
  logic [31:0]               reaction_max;
  logic [31:0]               reaction_mean;
  logic                      mean_up;

  // Datapath of one event.
  logic [16:0]               fmag;
  logic [16:0]               rmag;
  logic                      stop_hit;
  logic [TIME_BITS-1:0]      elapsed;
  logic [31:0]               react_x;
  logic                      moving;
  logic                      reduced;
  logic                      level_alarm;
  logic                      override_hit;
  logic [COUNT_BITS-1:0]     react_n;
  logic [31:0]               mean_diff;
  logic                      div_start;
  logic [ssrm_pkg::QUO_W-1:0] div_quo;
  ssrm_pkg::div_stat_t       div_stat;
  logic [31:0]               cnt32 [ssrm_pkg::NUM_CNT];

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Elapsed time since the emergency stamp, clipped at zero and saturated.
  assign elapsed = (item_time >= emergency_time) ? (item_time - emergency_time) : '0;

  generate
    if (TIME_BITS > 32) begin : g_time_sat
      assign react_x = (|elapsed[TIME_BITS-1:32]) ? '1 : elapsed[31:0];
    end else begin : g_time_fit
      assign react_x = 32'(elapsed);
    end
  endgenerate

  // Counters are shown saturated to 32 bits.
  generate
    for (genvar k = 0; k < ssrm_pkg::NUM_CNT; k++) begin : g_cnt_out
      if (COUNT_BITS > 32) begin : g_sat
        assign cnt32[k] = (|cnt[k][COUNT_BITS-1:32]) ? '1 : cnt[k][31:0];
      end else begin : g_fit
        assign cnt32[k] = 32'(cnt[k]);
      end
    end
  endgenerate

  // Stop and override decisions for a final command.
  always_comb begin
    fmag         = ssrm_pkg::mag16(item_speed);
    rmag         = ssrm_pkg::mag16(raw_speed_reg);
    stop_hit     = stop_pending && (fmag <= {2'b00, stop_threshold});
    moving       = rmag > {2'b00, stop_threshold};
    reduced      = ({1'b0, fmag} + {3'b000, override_margin}) < {1'b0, rmag};
    level_alarm  = (level_reg == ssrm_pkg::LEVEL_EMERG) ||
                   (level_reg == ssrm_pkg::LEVEL_HAZARD);
    override_hit = raw_seen && level_seen && level_alarm && moving && reduced;
    react_n      = bump(cnt[ssrm_pkg::CNT_REACT]);
    mean_diff    = (react_x >= reaction_mean) ? (react_x - reaction_mean)
                                              : (reaction_mean - react_x);
    div_start    = (state == ST_EXEC) && (item_kind == ssrm_pkg::KIND_FINAL) && stop_hit;
  end

  ssrm_divider #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mean_diff),
    .divisor  (react_n),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // Configuration writes are taken at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_threshold  <= ssrm_pkg::STOP_THRESHOLD_RST;
      override_margin <= ssrm_pkg::OVERRIDE_MARGIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssrm_pkg::REG_STOP_THRESHOLD:  stop_threshold  <= cfg_data[ssrm_pkg::SPEED_CFG_W-1:0];
        ssrm_pkg::REG_OVERRIDE_MARGIN: override_margin <= cfg_data[ssrm_pkg::SPEED_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and monitor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      level_reg      <= ssrm_pkg::LEVEL_FREE;
      level_seen     <= 1'b0;
      raw_speed_reg  <= '0;
      raw_seen       <= 1'b0;
      stop_pending   <= 1'b0;
      emergency_time <= '0;
      for (int k = 0; k < ssrm_pkg::NUM_CNT; k++) begin
        cnt[k] <= '0;
      end
      reaction_min   <= '1;
      reaction_max   <= '0;
      reaction_mean  <= '0;
      mean_up        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            item_kind  <= s_axis_tuser;
            item_time  <= TIME_BITS'(s_axis_tdata[ssrm_pkg::IN_TIME_LSB +: ssrm_pkg::IN_TIME_W]);
            item_level <= s_axis_tdata[ssrm_pkg::IN_LEVEL_LSB +: 16];
            item_speed <= s_axis_tdata[ssrm_pkg::IN_SPEED_LSB +: 16];
            state      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          // A recorded reaction time continues into the mean update.
          state <= div_start ? ST_DIV : ST_OUT;
          case (item_kind)
            ssrm_pkg::KIND_LEVEL: begin
              if (item_level == ssrm_pkg::LEVEL_EMERG) begin
                cnt[ssrm_pkg::CNT_EMERG] <= bump(cnt[ssrm_pkg::CNT_EMERG]);
                emergency_time <= item_time;
                stop_pending   <= 1'b1;
              end else if (item_level == ssrm_pkg::LEVEL_HAZARD) begin
                cnt[ssrm_pkg::CNT_HAZARD] <= bump(cnt[ssrm_pkg::CNT_HAZARD]);
              end else if (item_level == ssrm_pkg::LEVEL_FREE) begin
                cnt[ssrm_pkg::CNT_FREE] <= bump(cnt[ssrm_pkg::CNT_FREE]);
              end
              if (level_seen && (item_level != level_reg)) begin
                cnt[ssrm_pkg::CNT_CHANGE] <= bump(cnt[ssrm_pkg::CNT_CHANGE]);
              end
              level_reg  <= item_level;
              level_seen <= 1'b1;
            end
            ssrm_pkg::KIND_RAW: begin
              raw_speed_reg <= item_speed;
              raw_seen      <= 1'b1;
            end
            ssrm_pkg::KIND_FINAL: begin
              if (stop_hit) begin
                cnt[ssrm_pkg::CNT_REACT] <= react_n;
                if (react_x < reaction_min) begin
                  reaction_min <= react_x;
                end
                if (react_x > reaction_max) begin
                  reaction_max <= react_x;
                end
                mean_up      <= react_x >= reaction_mean;
                stop_pending <= 1'b0;
              end
              if (override_hit) begin
                cnt[ssrm_pkg::CNT_OVERRIDE] <= bump(cnt[ssrm_pkg::CNT_OVERRIDE]);
              end
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          // Apply the truncated step toward the new sample.
          if (div_stat.done) begin
            reaction_mean <= mean_up ? (reaction_mean + div_quo) : (reaction_mean - div_quo);
            state         <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);

  // Result word, assembled from the state left by the item.
  assign m_axis_tdata = {7'b0000000, stop_pending, reaction_mean, reaction_max, reaction_min,
                         cnt32[ssrm_pkg::CNT_REACT], cnt32[ssrm_pkg::CNT_OVERRIDE],
                         cnt32[ssrm_pkg::CNT_CHANGE], cnt32[ssrm_pkg::CNT_FREE],
                         cnt32[ssrm_pkg::CNT_HAZARD], cnt32[ssrm_pkg::CNT_EMERG],
                         level_reg};

  // A result and a new input transfer are never offered together.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // An accepted item closes the input until its result is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input reopened right after a transfer");

  // The stop timer is armed only by an emergency level report.
  a_arm_source: assert property (@(posedge clk) disable iff (rst)
    $rose(stop_pending) |-> ($past(state) == ST_EXEC &&
                             item_kind == ssrm_pkg::KIND_LEVEL &&
                             item_level == ssrm_pkg::LEVEL_EMERG))
    else $error("stop timer armed without an emergency");

  // Once a reaction is recorded the extremes stay ordered.
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && cnt[ssrm_pkg::CNT_REACT] != '0) |-> (reaction_min <= reaction_max))
    else $error("reaction minimum above maximum");

  // The divider only runs while the sequencer waits for the mean update.
  a_div_window: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == ST_DIV))
    else $error("divider busy outside the mean update");

endmodule

[tb/safety_stop_reaction_monitor_unit_tb.sv]
// Self-checking testbench for the safety stop reaction monitor: directed table, then random traffic.
`timescale 1ns / 1ps

module safety_stop_reaction_monitor_unit_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int SEG_ITEMS  = 238;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [ssrm_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [ssrm_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  // Result fields, highest bits first, so the struct matches tdata[304:0].
  typedef struct packed {
    logic               awaiting_stop;
    logic [31:0]        reaction_mean_us;
    logic [31:0]        reaction_max_us;
    logic [31:0]        reaction_min_us;
    logic [31:0]        reaction_total;
    logic [31:0]        override_total;
    logic [31:0]        change_total;
    logic [31:0]        free_total;
    logic [31:0]        hazard_total;
    logic [31:0]        emergency_total;
    logic signed [15:0] level_now;
  } stats_t;

  // One stimulus row; has_exp marks a row whose result is typed in.
  typedef struct packed {
    logic [1:0]         kind;
    logic [47:0]        t_us;
    logic signed [15:0] level;
    logic signed [15:0] speed;
    logic               has_exp;
    stats_t             exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ssrm_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [ssrm_pkg::IN_TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ssrm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ssrm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ssrm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  safety_stop_reaction_monitor_unit uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: a private copy of the configuration and statistics.
  logic [14:0]        stop_thr = ssrm_pkg::STOP_THRESHOLD_RST;
  logic [14:0]        undercut_margin = ssrm_pkg::OVERRIDE_MARGIN_RST;
  logic signed [15:0] cur_level = ssrm_pkg::LEVEL_FREE;
  logic               have_level = 1'b0;
  logic signed [15:0] last_raw = '0;
  logic               have_raw = 1'b0;
  logic               armed = 1'b0;
  logic [47:0]        emerg_stamp = '0;
  logic [31:0]        tally [ssrm_pkg::NUM_CNT];
  logic [31:0]        fastest_us = '1;
  logic [31:0]        slowest_us = '0;
  logic [31:0]        avg_us = '0;

  stats_t pending_stats[$];
  logic   drv_has_exp = 1'b0;
  stats_t drv_exp = '0;

  int src_idle_pct = 18;
  int dst_idle_pct = 50;
  int idle_cycles = 0;
  int errors = 0;
  int items_in = 0;
  int results_checked = 0;
  int settings_used = 1;
  int directed_count = 0;
  logic [47:0] now_us = '0;

  initial begin
    for (int k = 0; k < ssrm_pkg::NUM_CNT; k++) tally[k] = '0;
  end

  function automatic stats_t mk_stats(logic signed [15:0] lvl, logic [31:0] emerg,
      logic [31:0] hazard, logic [31:0] free_n, logic [31:0] change, logic [31:0] overr,
      logic [31:0] react, logic [31:0] rmin, logic [31:0] rmax, logic [31:0] rmean,
      logic aw);
    stats_t s;
    s.level_now = lvl;
    s.emergency_total = emerg;
    s.hazard_total = hazard;
    s.free_total = free_n;
    s.change_total = change;
    s.override_total = overr;
    s.reaction_total = react;
    s.reaction_min_us = rmin;
    s.reaction_max_us = rmax;
    s.reaction_mean_us = rmean;
    s.awaiting_stop = aw;
    return s;
  endfunction

  function automatic row_t stim_row(logic [1:0] kind, logic [47:0] t_us,
      logic signed [15:0] lvl, logic signed [15:0] spd);
    row_t r;
    r.kind = kind;
    r.t_us = t_us;
    r.level = lvl;
    r.speed = spd;
    r.has_exp = 1'b0;
    r.exp = '0;
    return r;
  endfunction

  function automatic row_t typed_row(logic [1:0] kind, logic [47:0] t_us,
      logic signed [15:0] lvl, logic signed [15:0] spd, stats_t e);
    row_t r;
    r = stim_row(kind, t_us, lvl, spd);
    r.has_exp = 1'b1;
    r.exp = e;
    return r;
  endfunction

  function automatic int mag_of(logic signed [15:0] v);
    int s;
    s = v;
    return (s < 0) ? -s : s;
  endfunction

  function automatic void bump(int k);
    if (tally[k] != 32'hFFFF_FFFF) tally[k] = tally[k] + 32'd1;
  endfunction

  // Advance the statistics by one event and return what the block should report.
  function automatic stats_t next_stop_stats(logic [1:0] kind, logic [47:0] t_us,
      logic signed [15:0] lvl, logic signed [15:0] spd);
    int fmag;
    int rmag;
    logic [47:0] dt;
    logic [31:0] x;
    if (kind == ssrm_pkg::KIND_LEVEL) begin
      if (lvl == ssrm_pkg::LEVEL_EMERG) bump(ssrm_pkg::CNT_EMERG);
      else if (lvl == ssrm_pkg::LEVEL_HAZARD) bump(ssrm_pkg::CNT_HAZARD);
      else if (lvl == ssrm_pkg::LEVEL_FREE) bump(ssrm_pkg::CNT_FREE);
      if (have_level && lvl != cur_level) bump(ssrm_pkg::CNT_CHANGE);
      cur_level = lvl;
      have_level = 1'b1;
      if (lvl == ssrm_pkg::LEVEL_EMERG) begin
        emerg_stamp = t_us;
        armed = 1'b1;
      end
    end else if (kind == ssrm_pkg::KIND_RAW) begin
      last_raw = spd;
      have_raw = 1'b1;
    end else if (kind == ssrm_pkg::KIND_FINAL) begin
      fmag = mag_of(spd);
      // First stopped command after an emergency closes the reaction window.
      if (armed && fmag <= int'(stop_thr)) begin
        dt = (t_us >= emerg_stamp) ? t_us - emerg_stamp : 48'd0;
        x = (dt > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : dt[31:0];
        bump(ssrm_pkg::CNT_REACT);
        if (x < fastest_us) fastest_us = x;
        if (x > slowest_us) slowest_us = x;
        if (x >= avg_us) avg_us = avg_us + (x - avg_us) / tally[ssrm_pkg::CNT_REACT];
        else avg_us = avg_us - (avg_us - x) / tally[ssrm_pkg::CNT_REACT];
        armed = 1'b0;
      end
      // Override: a moving raw command cut down while the level is unsafe.
      if (have_raw && have_level) begin
        rmag = mag_of(last_raw);
        if ((cur_level == ssrm_pkg::LEVEL_EMERG || cur_level == ssrm_pkg::LEVEL_HAZARD) &&
            rmag > int'(stop_thr) && fmag + int'(undercut_margin) < rmag)
          bump(ssrm_pkg::CNT_OVERRIDE);
      end
    end
    return mk_stats(cur_level, tally[ssrm_pkg::CNT_EMERG], tally[ssrm_pkg::CNT_HAZARD],
                    tally[ssrm_pkg::CNT_FREE], tally[ssrm_pkg::CNT_CHANGE],
                    tally[ssrm_pkg::CNT_OVERRIDE], tally[ssrm_pkg::CNT_REACT],
                    fastest_us, slowest_us, avg_us, armed);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_stats(stats_t e, stats_t a);
    check_field("level_now", {16'd0, e.level_now}, {16'd0, a.level_now});
    check_field("emergency_total", e.emergency_total, a.emergency_total);
    check_field("hazard_total", e.hazard_total, a.hazard_total);
    check_field("free_total", e.free_total, a.free_total);
    check_field("change_total", e.change_total, a.change_total);
    check_field("override_total", e.override_total, a.override_total);
    check_field("reaction_total", e.reaction_total, a.reaction_total);
    check_field("reaction_min_us", e.reaction_min_us, a.reaction_min_us);
    check_field("reaction_max_us", e.reaction_max_us, a.reaction_max_us);
    check_field("reaction_mean_us", e.reaction_mean_us, a.reaction_mean_us);
    check_field("awaiting_stop", {31'd0, e.awaiting_stop}, {31'd0, a.awaiting_stop});
  endtask

  // Monitor: mirror register writes, predict on each input transfer, check each output.
  always @(posedge clk) begin
    stats_t got;
    stats_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ssrm_pkg::REG_STOP_THRESHOLD) stop_thr = cfg_data[14:0];
        else if (cfg_index == ssrm_pkg::REG_OVERRIDE_MARGIN) undercut_margin = cfg_data[14:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = next_stop_stats(s_axis_tuser,
                               s_axis_tdata[ssrm_pkg::IN_TIME_LSB +: ssrm_pkg::IN_TIME_W],
                               s_axis_tdata[ssrm_pkg::IN_LEVEL_LSB +: 16],
                               s_axis_tdata[ssrm_pkg::IN_SPEED_LSB +: 16]);
        pending_stats.push_back(drv_has_exp ? drv_exp : want);
        items_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[304:0];
        if (pending_stats.size() == 0) begin
          errors++;
          $display("%0t ns: result transfer with nothing expected, actual 0x%0h",
                   $time, got);
        end else begin
          check_stats(pending_stats.pop_front(), got);
          results_checked++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending_stats.size());
      $display("== FAIL ==");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Receiver: ready is dropped in the current share of cycles.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99, 0) >= dst_idle_pct);
  end

  // Drive one item from a falling edge and return at the falling edge after its transfer.
  task automatic send_item(row_t r);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.kind;
    s_axis_tdata <= {r.speed, r.level, r.t_us};
    drv_has_exp <= r.has_exp;
    drv_exp <= r.exp;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
  endtask

  // Hold off the sender until every expected result has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_stats.size() != 0);
  endtask

  // Register write; the caller lowers cfg_valid after the last one.
  task automatic write_reg(logic [ssrm_pkg::CFG_INDEX_W-1:0] idx,
      logic [ssrm_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
  endtask

  task automatic set_regs(logic [ssrm_pkg::CFG_DATA_W-1:0] thr,
      logic [ssrm_pkg::CFG_DATA_W-1:0] margin);
    drain();
    write_reg(ssrm_pkg::REG_STOP_THRESHOLD, thr);
    write_reg(ssrm_pkg::REG_OVERRIDE_MARGIN, margin);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly small forward steps, sometimes long gaps or a step back in time.
  function automatic logic [47:0] advance_clock();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 80) now_us = now_us + 48'($urandom_range(5000, 1));
    else if (pick < 92) now_us = now_us + 48'($urandom_range(32'h10_0000, 5000));
    else if (pick < 97) now_us = now_us + 48'({2'($urandom_range(3, 0)), $urandom()});
    else now_us = now_us - 48'($urandom_range(20000, 1));
    return now_us;
  endfunction

  function automatic logic signed [15:0] signed_mag(int m);
    if (m >= 32768) return 16'sh8000;
    return ($urandom_range(1, 0) != 0) ? 16'(-m) : 16'(m);
  endfunction

  function automatic logic signed [15:0] stopped_speed();
    return signed_mag($urandom_range(int'(stop_thr), 0));
  endfunction

  function automatic logic signed [15:0] moving_speed();
    return signed_mag($urandom_range(32768, int'(stop_thr) + 1));
  endfunction

  // Random junk: any kind, any timestamp, any level.
  task automatic send_noise();
    logic [47:0] t;
    logic signed [15:0] lvl;
    t = ($urandom_range(1, 0) != 0) ? 48'({$urandom(), $urandom()}) : advance_clock();
    lvl = ($urandom_range(1, 0) != 0) ? 16'($urandom()) : 16'($urandom_range(3, 0));
    send_item(stim_row(2'($urandom_range(3, 0)), t, lvl, 16'($urandom())));
  endtask

  // A stop episode: motion, an emergency, slowing commands, usually a stop, then a release level.
  task automatic send_episode();
    logic signed [15:0] raw;
    if ($urandom_range(99, 0) < 3) drain();
    raw = moving_speed();
    send_item(stim_row(ssrm_pkg::KIND_RAW, advance_clock(), 0, raw));
    if ($urandom_range(1, 0) != 0) begin
      send_item(stim_row(ssrm_pkg::KIND_LEVEL, advance_clock(), ssrm_pkg::LEVEL_HAZARD, 0));
      send_item(stim_row(ssrm_pkg::KIND_FINAL, advance_clock(), 0,
                         signed_mag($urandom_range(mag_of(raw), 0))));
    end
    send_item(stim_row(ssrm_pkg::KIND_LEVEL, advance_clock(), ssrm_pkg::LEVEL_EMERG, 0));
    repeat ($urandom_range(3, 0)) begin
      if ($urandom_range(3, 0) == 0) begin
        raw = moving_speed();
        send_item(stim_row(ssrm_pkg::KIND_RAW, advance_clock(), 0, raw));
      end
      send_item(stim_row(ssrm_pkg::KIND_FINAL, advance_clock(), 0,
                         signed_mag($urandom_range(mag_of(raw), 0))));
    end
    if ($urandom_range(4, 0) == 0)
      send_item(stim_row(ssrm_pkg::KIND_LEVEL, advance_clock(), ssrm_pkg::LEVEL_EMERG, 0));
    if ($urandom_range(9, 0) != 0)
      send_item(stim_row(ssrm_pkg::KIND_FINAL, advance_clock(), 0, stopped_speed()));
    send_item(stim_row(ssrm_pkg::KIND_LEVEL, advance_clock(),
                       ($urandom_range(3, 0) != 0) ? ssrm_pkg::LEVEL_FREE
                                                   : ssrm_pkg::LEVEL_HAZARD, 0));
  endtask

  task automatic run_segment();
    int target;
    target = items_in + SEG_ITEMS;
    while (items_in < target) begin
      if ($urandom_range(99, 0) < 25) send_noise();
      else send_episode();
    end
  endtask

  initial begin
    row_t steps[$];
    // Directed table: reset view, stop timing, overrides, odd levels and times.
    steps.push_back(typed_row(KIND_UNKNOWN, 48'hFFFF_FFFF_FFFF, 16'sh7FFF, 16'sh8000,
                    mk_stats(ssrm_pkg::LEVEL_FREE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0,
                             1'b0)));
    steps.push_back(typed_row(ssrm_pkg::KIND_LEVEL, 48'd1000, ssrm_pkg::LEVEL_EMERG, 16'shFFFF,
                    mk_stats(ssrm_pkg::LEVEL_EMERG, 1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0,
                             1'b1)));
    steps.push_back(typed_row(ssrm_pkg::KIND_FINAL, 48'd1500, 16'sh7FFF, 16'sd0,
                    mk_stats(ssrm_pkg::LEVEL_EMERG, 1, 0, 0, 0, 0, 1, 500, 500, 500, 1'b0)));
    steps.push_back(stim_row(ssrm_pkg::KIND_FINAL, 48'd1600, 0, 16'sd0));
    steps.push_back(stim_row(ssrm_pkg::KIND_RAW, 48'd1700, 0, 16'sh8000));
    steps.push_back(stim_row(ssrm_pkg::KIND_LEVEL, 48'd1800, ssrm_pkg::LEVEL_HAZARD, 0));
    steps.push_back(stim_row(ssrm_pkg::KIND_FINAL, 48'd1900, 0, 16'sd100));
    steps.push_back(stim_row(ssrm_pkg::KIND_FINAL, 48'd1950, 0, 16'sh8000));
    steps.push_back(stim_row(ssrm_pkg::KIND_LEVEL, 48'd2000, ssrm_pkg::LEVEL_FREE, 0));
    steps.push_back(stim_row(ssrm_pkg::KIND_LEVEL, 48'd3000, ssrm_pkg::LEVEL_EMERG, 0));
    // A second emergency restarts the timer.
    steps.push_back(stim_row(ssrm_pkg::KIND_LEVEL, 48'd4000, ssrm_pkg::LEVEL_EMERG, 0));
    steps.push_back(stim_row(ssrm_pkg::KIND_FINAL, 48'd4500, 0, 16'sd31));
    steps.push_back(stim_row(ssrm_pkg::KIND_FINAL, 48'd5000, 0, -16'sd30));
    // Reaction longer than 32 bits saturates.
    steps.push_back(stim_row(ssrm_pkg::KIND_LEVEL, 48'd0, ssrm_pkg::LEVEL_EMERG, 0));
    steps.push_back(stim_row(ssrm_pkg::KIND_FINAL, 48'h1_0000_0007, 0, 16'sd0));
    // A stop stamped before its emergency counts as zero.
    steps.push_back(stim_row(ssrm_pkg::KIND_LEVEL, 48'hFFFF_FFFF_FFFF, ssrm_pkg::LEVEL_EMERG, 0));
    steps.push_back(stim_row(ssrm_pkg::KIND_FINAL, 48'd5, 0, 16'sd0));
    // Levels outside the known codes still register as changes.
    steps.push_back(stim_row(ssrm_pkg::KIND_LEVEL, 48'd6000, 16'sh8000, 0));
    steps.push_back(stim_row(ssrm_pkg::KIND_LEVEL, 48'd6100, 16'sh7FFF, 0));
    steps.push_back(stim_row(ssrm_pkg::KIND_LEVEL, 48'd6200, 16'sd3, 0));
    steps.push_back(stim_row(ssrm_pkg::KIND_RAW, 48'd6300, 0, 16'sh7FFF));
    steps.push_back(stim_row(ssrm_pkg::KIND_LEVEL, 48'd6400, ssrm_pkg::LEVEL_HAZARD, 0));
    steps.push_back(stim_row(ssrm_pkg::KIND_FINAL, 48'd6500, 0, 16'sh7FFF));
    steps.push_back(stim_row(ssrm_pkg::KIND_RAW, 48'd6600, 0, 16'sd0));
    steps.push_back(stim_row(ssrm_pkg::KIND_FINAL, 48'd6700, 0, 16'sd0));
    steps.push_back(stim_row(KIND_UNKNOWN, 48'd0, ssrm_pkg::LEVEL_EMERG, 16'sd0));
    directed_count = steps.size();
    now_us = 48'd10000;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (steps[i]) send_item(steps[i]);

    // Defaults written back explicitly; unused indexes must change nothing.
    drain();
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h8000);
    cfg_valid <= 1'b0;
    set_regs(16'd30, 16'd50);
    run_segment();
    set_regs(16'd0, 16'd0);
    run_segment();

    src_idle_pct = 50;
    dst_idle_pct = 18;
    // Top bit of the write data is beyond the register and dropped.
    set_regs(16'hFFFF, 16'h7FFF);
    run_segment();
    set_regs($urandom_range(2000, 0), $urandom_range(500, 0));
    run_segment();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    set_regs($urandom_range(300, 10), $urandom_range(32767, 0));
    run_segment();
    set_regs(16'h801E, 16'h8032);
    run_segment();

    drain();
    repeat (50) @(posedge clk);
    if (pending_stats.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected results never arrived", $time, pending_stats.size());
    end
    $display("Sent %0d items (%0d from the directed table), checked %0d results, %0d settings.",
             items_in, directed_count, results_checked, settings_used);
    $display("Reaction times recorded: %0d, overrides: %0d, mismatches: %0d.",
             tally[ssrm_pkg::CNT_REACT], tally[ssrm_pkg::CNT_OVERRIDE], errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[safety_stop_reaction_monitor_unit.f]
rtl/core/ssrm_pkg.sv
rtl/core/ssrm_divider.sv
rtl/core/safety_stop_reaction_monitor_unit.sv
tb/safety_stop_reaction_monitor_unit_tb.sv
